>>> rtl/msjd_pkg.sv
// ----------------------------------------------------------------------------
// msjd_pkg
// Shared types and constants of the motion step jitter detector.
// ----------------------------------------------------------------------------
`default_nettype none

package msjd_pkg;

	localparam int POS_W   = 32;
	localparam int STAMP_W = 32;
	localparam int STEP_W  = 34;
	localparam int CNT_W   = 32;
	localparam int REG_W   = 16;

	localparam logic [2:0] ST_DUP     = 3'd0;
	localparam logic [2:0] ST_RESTART = 3'd1;
	localparam logic [2:0] ST_STEP    = 3'd2;
	localparam logic [2:0] ST_EVEN    = 3'd3;
	localparam logic [2:0] ST_UNEVEN  = 3'd4;

	localparam logic [2:0] ADDR_STEP_FLOOR      = 3'd0;
	localparam logic [2:0] ADDR_UNEVEN_FRACTION = 3'd4;

	localparam logic [REG_W-1:0] STEP_FLOOR_RST      = 16'd66;
	localparam logic [REG_W-1:0] UNEVEN_FRACTION_RST = 16'd3277;

	typedef struct packed {
		logic [STAMP_W-1:0]      frame_no;
		logic signed [POS_W-1:0] pos_z;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_x;
	} item_t;

	typedef struct packed {
		logic [REG_W-1:0] uneven_fraction;
		logic [REG_W-1:0] step_floor;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] worst_seen;
		logic [CNT_W-1:0] uneven_total;
		logic [CNT_W-1:0] judged_total;
		logic [CNT_W-1:0] deviation;
		logic [2:0]       status;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/msjd_front.sv
// ----------------------------------------------------------------------------
// msjd_front
// Accepts input beats and reduces the object index modulo the object count.
// ----------------------------------------------------------------------------
`default_nettype none

module msjd_front #(
	parameter int NUM_OBJECTS = 256,
	parameter int OBJ_W       = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         in_index,
	input  wire msjd_pkg::item_t    in_item,
	output logic                    push,
	input  wire logic               push_ready,
	output logic [OBJ_W-1:0]        push_obj,
	output msjd_pkg::item_t         push_item
);
	import msjd_pkg::*;

	localparam int NI = 256;

	typedef enum logic {F_IDLE, F_PUSH} fstate_t;

	// reduced index for every possible 8-bit index
	function automatic logic [NI*OBJ_W-1:0] build_tab();
		logic [NI*OBJ_W-1:0] t;
		t = '0;
		for (int i = 0; i < NI; i++) t[i*OBJ_W +: OBJ_W] = OBJ_W'(i % NUM_OBJECTS);
		return t;
	endfunction

	localparam logic [NI*OBJ_W-1:0] RED_TAB = build_tab();

	fstate_t          state_q;
	logic [OBJ_W-1:0] r_q;
	item_t            item_q;
	logic [OBJ_W-1:0] red_obj;

	assign in_ready  = (state_q == F_IDLE);
	assign push      = (state_q == F_PUSH);
	assign push_obj  = r_q;
	assign push_item = item_q;
	assign red_obj   = RED_TAB[int'(in_index) * OBJ_W +: OBJ_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			if (state_q == F_IDLE) begin
				if (in_valid) state_q <= F_PUSH;
			end else begin
				if (push_ready) state_q <= F_IDLE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			r_q    <= red_obj;
			item_q <= in_item;
		end
	end

endmodule

`default_nettype wire

>>> rtl/msjd_queue.sv
// ----------------------------------------------------------------------------
// msjd_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module msjd_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              push_ready,
	input  wire logic [W-1:0] push_data,
	output logic              pop_valid,
	input  wire logic         pop,
	output logic [W-1:0]      pop_data
);
	logic [W-1:0] data_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic         do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = data_q[rp_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) data_q[wp_q] <= push_data;
	end

endmodule

`default_nettype wire

>>> rtl/msjd_back.sv
// ----------------------------------------------------------------------------
// msjd_back
// Per-object history, step length, judgment and running tallies.
// ----------------------------------------------------------------------------
`default_nettype none

module msjd_back #(
	parameter int NUM_OBJECTS = 256,
	parameter int FRAC_BITS   = 16,
	parameter int OBJ_W       = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire msjd_pkg::cfg_t   cfg,
	input  wire logic             q_valid,
	output logic                  q_pop,
	input  wire logic [OBJ_W-1:0] q_obj,
	input  wire msjd_pkg::item_t  q_item,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output msjd_pkg::result_t     res
);
	import msjd_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_CHK, S_MUL, S_SQRT, S_JUDGE, S_DIV, S_FIN} bstate_t;

	// he and hm mark that earlier and middle hold real steps
	typedef struct packed {
		logic                he;
		logic                hm;
		logic [STEP_W-1:0]   middle;
		logic [STEP_W-1:0]   earlier;
		logic [STAMP_W-1:0]  stamp;
		logic [POS_W-1:0]    lz;
		logic [POS_W-1:0]    ly;
		logic [POS_W-1:0]    lx;
	} entry_t;

	localparam int DW  = STEP_W + FRAC_BITS;
	localparam int EW  = $bits(entry_t);
	localparam int DCW = $clog2(DW + 1);

	logic [EW-1:0]          mem_q [NUM_OBJECTS];
	entry_t                 rd_q;
	logic [NUM_OBJECTS-1:0] seen_q;

	bstate_t           state_q;
	logic [OBJ_W-1:0]  obj_q;
	item_t             item_q;
	logic [2:0]        status_q;
	logic              wr_q, judged_q;
	logic [32:0]       ax_q, ay_q, az_q;
	logic [3:0]        mcnt_q;
	logic [33:0]       prod_q;
	logic [5:0]        sh_q;
	logic              pv_q;
	logic [67:0]       acc_q;
	logic [STEP_W-1:0] root_q;
	logic [36:0]       srem_q;
	logic [5:0]        scnt_q;
	logic [DW-1:0]     dd_q;
	logic [STEP_W-1:0] mean_q, drem_q;
	logic [DCW-1:0]    dcnt_q;
	logic [CNT_W-1:0]  judged_q_cnt, uneven_q_cnt, worst_q;
	result_t           res_q;
	logic              res_valid_q;

	logic              commit;
	logic [16:0]       op_a, op_b;
	logic [5:0]        op_sh;
	logic [36:0]       s_r2, s_trial;
	logic [STEP_W:0]   d_r2;
	logic [STEP_W:0]   msum;
	logic [STEP_W-1:0] mean_c, diff_c;
	logic              judge_ok;
	logic [CNT_W-1:0]  dev_c;

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign commit    = (state_q == S_FIN) && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	function automatic logic [32:0] absdiff(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] d;
		d = {a[31], a} - {b[31], b};
		return d[32] ? (~d + 33'd1) : d;
	endfunction

	// partial products: low*low, 2*high*low, high*high for each axis
	always_comb begin
		logic [32:0] a;
		logic [1:0]  part;
		priority if (mcnt_q < 4'd3) begin
			a = ax_q; part = 2'(mcnt_q);
		end else if (mcnt_q < 4'd6) begin
			a = ay_q; part = 2'(mcnt_q - 4'd3);
		end else begin
			a = az_q; part = 2'(mcnt_q - 4'd6);
		end
		unique case (part)
			2'd0: begin op_a = {1'b0, a[15:0]}; op_b = {1'b0, a[15:0]}; op_sh = 6'd0;  end
			2'd1: begin op_a = a[32:16];        op_b = {1'b0, a[15:0]}; op_sh = 6'd17; end
			default: begin op_a = a[32:16];     op_b = a[32:16];        op_sh = 6'd32; end
		endcase
	end

	assign s_r2    = {srem_q[34:0], acc_q[67:66]};
	assign s_trial = {1'b0, root_q, 2'b01};
	assign d_r2    = {drem_q, dd_q[DW-1]};
	assign msum    = {1'b0, rd_q.earlier} + {1'b0, root_q};
	assign mean_c  = msum[STEP_W:1];
	assign diff_c  = (rd_q.middle > mean_c) ? rd_q.middle - mean_c : mean_c - rd_q.middle;
	assign judge_ok = rd_q.he && rd_q.hm
		&& rd_q.earlier > STEP_W'(cfg.step_floor)
		&& rd_q.middle > STEP_W'(cfg.step_floor)
		&& root_q > STEP_W'(cfg.step_floor)
		&& mean_c != '0;
	assign dev_c = (|dd_q[DW-1:CNT_W]) ? {CNT_W{1'b1}} : dd_q[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			seen_q       <= '0;
			judged_q_cnt <= '0;
			uneven_q_cnt <= '0;
			worst_q      <= '0;
			res_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			if (commit) res_valid_q <= 1'b1;
			else if (res_valid_q && res_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (q_valid) state_q <= S_CHK;
				S_CHK: begin
					priority if (seen_q[obj_q] && rd_q.stamp == item_q.frame_no)
						state_q <= S_FIN;
					else if (seen_q[obj_q] && rd_q.stamp + 32'd1 == item_q.frame_no)
						state_q <= S_MUL;
					else
						state_q <= S_FIN;
				end
				S_MUL:   if (mcnt_q == 4'd9) state_q <= S_SQRT;
				S_SQRT:  if (scnt_q == 6'd33) state_q <= S_JUDGE;
				S_JUDGE: state_q <= judge_ok ? S_DIV : S_FIN;
				S_DIV:   if (dcnt_q == DCW'(DW - 1)) state_q <= S_FIN;
				S_FIN: begin
					if (commit) begin
						logic [2:0] st;
						st = status_q;
						if (judged_q) begin
							judged_q_cnt <= judged_q_cnt + 32'd1;
							st = ST_EVEN;
							if (dev_c > CNT_W'(cfg.uneven_fraction)) begin
								uneven_q_cnt <= uneven_q_cnt + 32'd1;
								st = ST_UNEVEN;
							end
							if (dev_c > worst_q) worst_q <= dev_c;
						end
						res_q.status       <= st;
						res_q.deviation    <= judged_q ? dev_c : '0;
						res_q.judged_total <= judged_q_cnt + 32'(judged_q);
						res_q.uneven_total <= uneven_q_cnt
							+ 32'(judged_q && dev_c > CNT_W'(cfg.uneven_fraction));
						res_q.worst_seen   <= (judged_q && dev_c > worst_q) ? dev_c : worst_q;
						if (status_q == ST_RESTART) seen_q[obj_q] <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (q_pop) begin
			obj_q  <= q_obj;
			item_q <= q_item;
			rd_q   <= mem_q[q_obj];
		end
		unique case (state_q)
			S_CHK: begin
				judged_q <= 1'b0;
				mcnt_q   <= '0;
				pv_q     <= 1'b0;
				acc_q    <= '0;
				root_q   <= '0;
				srem_q   <= '0;
				scnt_q   <= '0;
				ax_q     <= absdiff(item_q.pos_x, rd_q.lx);
				ay_q     <= absdiff(item_q.pos_y, rd_q.ly);
				az_q     <= absdiff(item_q.pos_z, rd_q.lz);
				priority if (seen_q[obj_q] && rd_q.stamp == item_q.frame_no) begin
					status_q <= ST_DUP;   wr_q <= 1'b0;
				end else if (seen_q[obj_q] && rd_q.stamp + 32'd1 == item_q.frame_no) begin
					status_q <= ST_STEP;  wr_q <= 1'b1;
				end else begin
					status_q <= ST_RESTART; wr_q <= 1'b1;
				end
			end
			S_MUL: begin
				if (pv_q) acc_q <= acc_q + (68'(prod_q) << sh_q);
				prod_q <= op_a * op_b;
				sh_q   <= op_sh;
				pv_q   <= (mcnt_q < 4'd9);
				mcnt_q <= mcnt_q + 4'd1;
			end
			S_SQRT: begin
				acc_q  <= acc_q << 2;
				scnt_q <= scnt_q + 6'd1;
				if (s_r2 >= s_trial) begin
					srem_q <= s_r2 - s_trial;
					root_q <= {root_q[STEP_W-2:0], 1'b1};
				end else begin
					srem_q <= s_r2;
					root_q <= {root_q[STEP_W-2:0], 1'b0};
				end
			end
			S_JUDGE: begin
				judged_q <= judge_ok;
				dd_q     <= {diff_c, {FRAC_BITS{1'b0}}};
				mean_q   <= mean_c;
				drem_q   <= '0;
				dcnt_q   <= '0;
			end
			S_DIV: begin
				dcnt_q <= dcnt_q + DCW'(1);
				if (d_r2 >= {1'b0, mean_q}) begin
					drem_q <= STEP_W'(d_r2 - {1'b0, mean_q});
					dd_q   <= {dd_q[DW-2:0], 1'b1};
				end else begin
					drem_q <= d_r2[STEP_W-1:0];
					dd_q   <= {dd_q[DW-2:0], 1'b0};
				end
			end
			default: ;
		endcase
		if (commit && wr_q) begin
			entry_t w;
			w.lx      = item_q.pos_x;
			w.ly      = item_q.pos_y;
			w.lz      = item_q.pos_z;
			w.stamp   = item_q.frame_no;
			w.earlier = rd_q.middle;
			w.middle  = root_q;
			// a restart clears both step marks, a step shifts them along
			w.he      = (status_q == ST_STEP) ? rd_q.hm : 1'b0;
			w.hm      = (status_q == ST_STEP);
			mem_q[obj_q] <= w;
		end
	end

endmodule

`default_nettype wire

>>> rtl/motion_step_jitter_detector.sv
// timing: a repeated stamp or a restart skips the arithmetic; an unjudged step
// runs the multiply and root iterations, a judged step also the divide iterations;
// queue waits and output stalls add to the time a beat takes
// flow: front takes one beat at a time and holds off input until the queue accepts
// it; back runs one beat at a time, from queue pop to output commit
// reset: asynchronous, clears record flags, tallies and registers to defaults
// ----------------------------------------------------------------------------
// motion_step_jitter_detector
// Flags uneven per-object motion from a stream of 3D position samples.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_step_jitter_detector #(
	parameter int NUM_OBJECTS = 256,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// object_index, pos_x, pos_y, pos_z, frame_no
	input  wire logic [135:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// status, deviation, judged_total, uneven_total, worst_seen, zero pad
	output logic [135:0]      m_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import msjd_pkg::*;

	localparam int OBJ_W = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
	localparam int QW    = OBJ_W + $bits(item_t);

	cfg_t             cfg_q;
	item_t            in_item;
	logic             f_push, f_ready, q_valid, q_pop;
	logic [OBJ_W-1:0] f_obj;
	item_t            f_item;
	logic [QW-1:0]    q_data;
	result_t          res;

	assign pready = 1'b1;
	assign in_item.pos_x    = s_tdata[39:8];
	assign in_item.pos_y    = s_tdata[71:40];
	assign in_item.pos_z    = s_tdata[103:72];
	assign in_item.frame_no = s_tdata[135:104];
	assign m_tdata = {5'd0, res.worst_seen, res.uneven_total, res.judged_total,
		res.deviation, res.status};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_floor      <= STEP_FLOOR_RST;
			cfg_q.uneven_fraction <= UNEVEN_FRACTION_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr == ADDR_STEP_FLOOR)      cfg_q.step_floor      <= pwdata[15:0];
			if (paddr == ADDR_UNEVEN_FRACTION) cfg_q.uneven_fraction <= pwdata[15:0];
		end
	end

	always_comb begin
		priority if (paddr == ADDR_STEP_FLOOR)      prdata = {16'd0, cfg_q.step_floor};
		else if (paddr == ADDR_UNEVEN_FRACTION)     prdata = {16'd0, cfg_q.uneven_fraction};
		else                                        prdata = '0;
	end

	msjd_front #(.NUM_OBJECTS(NUM_OBJECTS), .OBJ_W(OBJ_W)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_index(s_tdata[7:0]), .in_item(in_item),
		.push(f_push), .push_ready(f_ready),
		.push_obj(f_obj), .push_item(f_item)
	);

	msjd_queue #(.W(QW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(f_push), .push_ready(f_ready), .push_data({f_obj, f_item}),
		.pop_valid(q_valid), .pop(q_pop), .pop_data(q_data)
	);

	msjd_back #(.NUM_OBJECTS(NUM_OBJECTS), .FRAC_BITS(FRAC_BITS), .OBJ_W(OBJ_W)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_valid(q_valid), .q_pop(q_pop),
		.q_obj(q_data[QW-1 -: OBJ_W]), .q_item(q_data[$bits(item_t)-1:0]),
		.res_valid(m_tvalid), .res_ready(m_tready), .res(res)
	);

`ifndef NO_ASSERTIONS
	a_unjudged_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res.status == ST_DUP || res.status == ST_RESTART
		|| res.status == ST_STEP) |-> res.deviation == '0)
		else $error("unjudged beat carries a deviation");
	a_worst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res.worst_seen >= res.deviation)
		else $error("worst deviation below current deviation");
	a_uneven_le_judged: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.status == ST_UNEVEN
		|-> res.deviation > {16'd0, cfg_q.uneven_fraction})
		else $error("uneven beat below threshold");
`endif

endmodule

`default_nettype wire
